// File: src/four_level_page_table_walker_defines.svh
// assertion macros for the page table walker checker
// no dependencies; used by the port checker only
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// condition that must hold in the same cycle
`define FPTW_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define FPTW_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

// File: src/fptw_pkg.sv
// shared types and constants of the page table walker
// no dependencies
package fptw_pkg;

	localparam int IDX_W   = 9;
	localparam int ENTRY_W = 55;
	localparam int FRAME_W = 36;
	localparam int VA_W    = 48;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INVAL = 2'd1;
	localparam logic [1:0] ST_NOMEM = 2'd2;
	localparam logic [1:0] ST_NOENT = 2'd3;

	// write data select
	localparam logic [1:0] WD_ZERO = 2'd0;
	localparam logic [1:0] WD_LINK = 2'd1;
	localparam logic [1:0] WD_LEAF = 2'd2;

	// memory address select
	localparam logic [1:0] AS_SLOT  = 2'd0;
	localparam logic [1:0] AS_PAGE  = 2'd1;
	localparam logic [1:0] AS_SWEEP = 2'd2;

	typedef struct packed {
		logic       mem_rd;
		logic       mem_wr;
		logic [1:0] wr_sel;
		logic [1:0] addr_sel;
		logic       clr_inc;
		logic       clr_rst;
		logic       req_load;
		logic       lvl_inc;
		logic       page_off;
		logic       page_new;
		logic       alloc;
		logic       st_set;
		logic [1:0] st_code;
		logic       res_load;
	} fptw_cmd_t;

	typedef struct packed {
		logic is_map;
		logic bad_req;
		logic ent_valid;
		logic foreign;
		logic pool_full;
		logic clr_page_last;
		logic clr_sweep_last;
		logic lvl_pre_leaf;
		logic lvl_leaf;
		logic rsp_busy;
	} fptw_sts_t;

endpackage

// File: src/fptw_dp.sv
// datapath of the page table walker: table memory, request, walk and result registers
// depends on fptw_pkg
module fptw_dp import fptw_pkg::*; #(
	parameter int POOL_PAGES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [FRAME_W-1:0]   cfg_data,
	input  logic                 opcode,
	input  logic [VA_W-1:0]      virt_addr,
	input  logic [VA_W-1:0]      phys_page_addr,
	input  logic                 flag_user,
	input  logic                 flag_write,
	input  logic                 flag_exec,
	input  logic                 flag_guard,
	input  logic                 rsp_stall,
	input  fptw_cmd_t            cmd,
	output fptw_sts_t            sts,
	output logic                 rsp_valid,
	output logic [1:0]           status,
	output logic [VA_W-1:0]      phys_addr,
	output logic [ENTRY_W-1:0]   leaf_entry,
	output logic                 is_valid,
	output logic                 allows_user,
	output logic                 allows_write,
	output logic                 allows_el0_exec,
	output logic                 privileged_only
);

	localparam int PAGE_W = $clog2(POOL_PAGES);
	localparam int ADDR_W = PAGE_W + IDX_W;
	localparam int DEPTH  = POOL_PAGES * (2 ** IDX_W);
	localparam int CNT_W  = $clog2(POOL_PAGES + 1);
	localparam int LW     = (CNT_W > 7) ? CNT_W : 7;

	logic [FRAME_W-1:0] base_q;
	logic [6:0]         limit_q;
	logic               op_q, user_q, wr_q, ex_q, guard_q;
	logic [VA_W-1:0]    va_q, pa_q;
	logic [1:0]         lvl_q;
	logic [PAGE_W-1:0]  page_q;
	logic [CNT_W-1:0]   nf_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [1:0]         st_q;
	logic [ENTRY_W-1:0] rdata_q;
	logic               rsp_valid_q;

	logic [ENTRY_W-1:0] mem [DEPTH];

	logic [IDX_W-1:0]   idx;
	logic [ADDR_W-1:0]  addr;
	logic [ENTRY_W-1:0] wdata;
	logic [FRAME_W-1:0] off;
	logic [FRAME_W-1:0] new_frame;
	logic [LW-1:0]      lim_ext, pp_ext, lim;
	logic [1:0]         ap_new;
	logic               uxn_new, pxn_new;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			limit_q <= 7'd64;
		end else if (cfg_valid) begin
			if (cfg_index == 1'b0) base_q <= cfg_data;
			else                   limit_q <= cfg_data[6:0];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			op_q    <= opcode;
			va_q    <= virt_addr;
			pa_q    <= phys_page_addr;
			user_q  <= flag_user;
			wr_q    <= flag_write;
			ex_q    <= flag_exec;
			guard_q <= flag_guard;
		end
	end

	// index of the current level
	always_comb begin
		case (lvl_q)
			2'd0:    idx = va_q[47:39];
			2'd1:    idx = va_q[38:30];
			2'd2:    idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	// memory address and write data
	always_comb begin
		case (cmd.addr_sel)
			AS_PAGE:  addr = {nf_q[PAGE_W-1:0], clr_q[IDX_W-1:0]};
			AS_SWEEP: addr = clr_q;
			default:  addr = {page_q, idx};
		endcase
	end

	assign new_frame = base_q + FRAME_W'(nf_q);
	assign ap_new    = {~wr_q, user_q};
	assign uxn_new   = user_q ? ~ex_q : 1'b1;
	assign pxn_new   = user_q ? 1'b1 : ~ex_q;

	always_comb begin
		case (cmd.wr_sel)
			WD_LINK: wdata = {7'd0, new_frame, 10'd0, 2'b11};
			WD_LEAF: wdata = {uxn_new, pxn_new, 5'd0, pa_q[47:12], 1'b0, 1'b1, 2'b11,
				ap_new, 4'd0, 2'b11};
			default: wdata = '0;
		endcase
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) mem[addr] <= wdata;
		if (cmd.mem_rd) rdata_q <= mem[addr];
	end

	// walk position and allocator
	assign off = rdata_q[47:12] - base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= '0;
			page_q <= '0;
			nf_q   <= CNT_W'(1);
			clr_q  <= '0;
			st_q   <= ST_OK;
		end else begin
			if (cmd.req_load) begin
				lvl_q  <= '0;
				page_q <= '0;
			end else if (cmd.lvl_inc) begin
				lvl_q <= lvl_q + 2'd1;
			end
			if (cmd.page_off) page_q <= off[PAGE_W-1:0];
			if (cmd.page_new) page_q <= nf_q[PAGE_W-1:0];
			if (cmd.alloc) nf_q <= nf_q + CNT_W'(1);
			if (cmd.clr_rst) clr_q <= '0;
			else if (cmd.clr_inc) clr_q <= clr_q + ADDR_W'(1);
			if (cmd.st_set) st_q <= cmd.st_code;
		end
	end

	// pool limit
	assign lim_ext = LW'(limit_q);
	assign pp_ext  = LW'(POOL_PAGES);
	assign lim     = (lim_ext < pp_ext) ? lim_ext : pp_ext;

	assign sts.is_map         = ~op_q;
	assign sts.bad_req        = (va_q[11:0] != 12'd0) || (pa_q[11:0] != 12'd0) || guard_q;
	assign sts.ent_valid      = rdata_q[0];
	assign sts.foreign        = off >= FRAME_W'(POOL_PAGES);
	assign sts.pool_full      = LW'(nf_q) >= lim;
	assign sts.clr_page_last  = &clr_q[IDX_W-1:0];
	assign sts.clr_sweep_last = clr_q == ADDR_W'(DEPTH - 1);
	assign sts.lvl_pre_leaf   = lvl_q == 2'd2;
	assign sts.lvl_leaf       = lvl_q == 2'd3;
	assign sts.rsp_busy       = rsp_valid_q && rsp_stall;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status <= st_q;
			if (op_q && st_q == ST_OK) begin
				phys_addr       <= {rdata_q[47:12], va_q[11:0]};
				leaf_entry      <= rdata_q;
				is_valid        <= rdata_q[0];
				allows_user     <= rdata_q[6];
				allows_write    <= ~rdata_q[7];
				allows_el0_exec <= rdata_q[6] & ~rdata_q[54];
				privileged_only <= rdata_q[0] & ~rdata_q[6];
			end else begin
				phys_addr       <= '0;
				leaf_entry      <= '0;
				is_valid        <= 1'b0;
				allows_user     <= 1'b0;
				allows_write    <= 1'b0;
				allows_el0_exec <= 1'b0;
				privileged_only <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: src/fptw_ctrl.sv
// controller state machine of the page table walker
// depends on fptw_pkg
module fptw_ctrl import fptw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  fptw_sts_t sts,
	output fptw_cmd_t cmd
);

	localparam logic [3:0] S_SWEEP = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_READ  = 4'd3;
	localparam logic [3:0] S_EVAL  = 4'd4;
	localparam logic [3:0] S_CLEAR = 4'd5;
	localparam logic [3:0] S_LINK  = 4'd6;
	localparam logic [3:0] S_LEAF  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_SWEEP;
		else         state_q <= state_d;
	end

	assign req_stall = state_q != S_IDLE;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.wr_sel   = WD_ZERO;
		cmd.addr_sel = AS_SLOT;
		cmd.st_code  = ST_OK;
		case (state_q)
			S_SWEEP: begin
				cmd.mem_wr   = 1'b1;
				cmd.addr_sel = AS_SWEEP;
				cmd.clr_inc  = 1'b1;
				if (sts.clr_sweep_last) begin
					cmd.clr_rst = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_map && sts.bad_req) begin
					cmd.st_set  = 1'b1;
					cmd.st_code = ST_INVAL;
					state_d     = S_DONE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_EVAL;
			end
			S_EVAL: begin
				cmd.st_set = 1'b1;
				if (sts.lvl_leaf) begin
					cmd.st_code = sts.ent_valid ? ST_OK : ST_NOENT;
					state_d     = S_DONE;
				end else if (!sts.ent_valid) begin
					if (!sts.is_map) begin
						cmd.st_code = ST_NOENT;
						state_d     = S_DONE;
					end else if (sts.pool_full) begin
						cmd.st_code = ST_NOMEM;
						state_d     = S_DONE;
					end else begin
						cmd.st_set = 1'b0;
						state_d    = S_CLEAR;
					end
				end else if (sts.foreign) begin
					cmd.st_code = sts.is_map ? ST_INVAL : ST_NOENT;
					state_d     = S_DONE;
				end else begin
					cmd.st_set   = 1'b0;
					cmd.page_off = 1'b1;
					cmd.lvl_inc  = 1'b1;
					state_d      = (sts.is_map && sts.lvl_pre_leaf) ? S_LEAF : S_READ;
				end
			end
			S_CLEAR: begin
				cmd.mem_wr   = 1'b1;
				cmd.addr_sel = AS_PAGE;
				cmd.clr_inc  = 1'b1;
				if (sts.clr_page_last) begin
					cmd.clr_rst = 1'b1;
					state_d     = S_LINK;
				end
			end
			S_LINK: begin
				cmd.mem_wr   = 1'b1;
				cmd.wr_sel   = WD_LINK;
				cmd.page_new = 1'b1;
				cmd.alloc    = 1'b1;
				cmd.lvl_inc  = 1'b1;
				state_d      = sts.lvl_pre_leaf ? S_LEAF : S_READ;
			end
			S_LEAF: begin
				cmd.mem_wr  = 1'b1;
				cmd.wr_sel  = WD_LEAF;
				cmd.st_set  = 1'b1;
				cmd.st_code = ST_OK;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!sts.rsp_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: src/four_level_page_table_walker.sv
// top level of the four-level page table walker
// depends on fptw_pkg, fptw_ctrl, fptw_dp
//
// channel | signals                          | direction
// req     | req_valid, req_stall, fields     | in, stall out
// rsp     | rsp_valid, rsp_stall, fields     | out, stall in
// cfg     | cfg_valid, cfg_ready, index/data | in, ready out
//
// a query walks up to four levels, each a registered table read then an evaluate step, then loads the result
// a map clears each table it allocates (one entry cleared a cycle), then links it
// after reset the whole memory is cleared while req_stall is high
// the result register lets the next walk run while the previous beat still stalls
module four_level_page_table_walker import fptw_pkg::*; #(
	parameter int POOL_PAGES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [FRAME_W-1:0] cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               opcode,
	input  logic [VA_W-1:0]    virt_addr,
	input  logic [VA_W-1:0]    phys_page_addr,
	input  logic               flag_user,
	input  logic               flag_write,
	input  logic               flag_exec,
	input  logic               flag_guard,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [VA_W-1:0]    phys_addr,
	output logic [ENTRY_W-1:0] leaf_entry,
	output logic               is_valid,
	output logic               allows_user,
	output logic               allows_write,
	output logic               allows_el0_exec,
	output logic               privileged_only
);

	fptw_cmd_t cmd;
	fptw_sts_t sts;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	fptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fptw_dp #(.POOL_PAGES(POOL_PAGES)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.virt_addr       (virt_addr),
		.phys_page_addr  (phys_page_addr),
		.flag_user       (flag_user),
		.flag_write      (flag_write),
		.flag_exec       (flag_exec),
		.flag_guard      (flag_guard),
		.rsp_stall       (rsp_stall),
		.cmd             (cmd),
		.sts             (sts),
		.rsp_valid       (rsp_valid),
		.status          (status),
		.phys_addr       (phys_addr),
		.leaf_entry      (leaf_entry),
		.is_valid        (is_valid),
		.allows_user     (allows_user),
		.allows_write    (allows_write),
		.allows_el0_exec (allows_el0_exec),
		.privileged_only (privileged_only)
	);

endmodule

// File: src/fptw_checker.sv
// port checker of the page table walker, bound to the top level
// depends on fptw_pkg and four_level_page_table_walker_defines.svh
`include "four_level_page_table_walker_defines.svh"
module fptw_checker import fptw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [1:0]  status,
	input logic [47:0] phys_addr,
	input logic [54:0] leaf_entry,
	input logic        is_valid,
	input logic        allows_user,
	input logic        allows_el0_exec,
	input logic        privileged_only
);

	// a stalled result beat stays
	`FPTW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result beat dropped")

	// one walk at a time
	`FPTW_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "no stall after request")

	// failed requests carry no translation
	`FPTW_ASSERT_NOW(a_fail_zero, !rsp_valid || status == ST_OK || (phys_addr == 48'd0 && leaf_entry == 55'd0), "fields set on failure")

	// predicates agree with the leaf
	`FPTW_ASSERT_NOW(a_pred, !rsp_valid || (is_valid == leaf_entry[0] && (!allows_el0_exec || allows_user) && (!privileged_only || is_valid)), "predicates disagree with leaf")

endmodule

bind four_level_page_table_walker fptw_checker u_fptw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req_valid),
	.req_stall       (req_stall),
	.rsp_valid       (rsp_valid),
	.rsp_stall       (rsp_stall),
	.status          (status),
	.phys_addr       (phys_addr),
	.leaf_entry      (leaf_entry),
	.is_valid        (is_valid),
	.allows_user     (allows_user),
	.allows_el0_exec (allows_el0_exec),
	.privileged_only (privileged_only)
);
